>>> sv/cgr_pkg.sv
// Shared types, constants and the built-in 8x14 font for the glyph rasterizer.
`default_nettype none

package cgr_pkg;

    localparam int GLYPH_COLUMNS  = 8;
    localparam int GLYPH_ROWS     = 14;
    localparam int HALF_ROWS      = GLYPH_ROWS / 2;
    localparam int GLYPH_COUNT    = 96;
    localparam int FIRST_CODE     = 32;
    localparam int ROW_BIT_OFFSET = 2;
    localparam int COLOR_W        = 16;
    localparam int CODE_W         = 8;
    localparam int COL_W          = $clog2(GLYPH_COLUMNS);
    localparam int GLYPH_IDX_W    = $clog2(GLYPH_COUNT);
    localparam int ROW_BIT_W      = $clog2(COLOR_W);
    localparam int CFG_IDX_W      = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR = 2'd3;

    localparam logic [COLOR_W-1:0] FORE_COLOR_RST  = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BACK_COLOR_RST  = 16'h0000;
    localparam logic [COLOR_W-1:0] BLANK_COLOR_RST = 16'h0000;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [COLOR_W-1:0] font_word_t;
    typedef logic [GLYPH_COLUMNS-1:0][COLOR_W-1:0] glyph_bits_t;

    // One classified character waiting for the back end.
    typedef struct packed {
        logic        is_end;
        glyph_bits_t glyph;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    localparam font_word_t FONT_ROM [GLYPH_COUNT][GLYPH_COLUMNS] = '{
        '{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
        '{16'h0000,16'h0000,16'h1C00,16'h3F60,16'h3F60,16'h1C00,16'h0000,16'h0000},
        '{16'h0000,16'h7000,16'h7800,16'h0000,16'h0000,16'h0000,16'h7800,16'h7000},
        '{16'h0000,16'h0880,16'h3FE0,16'h3FE0,16'h0880,16'h3FE0,16'h3FE0,16'h0880},
        '{16'h0000,16'h1CC0,16'h3E60,16'h2220,16'hE238,16'hE238,16'h33E0,16'h19C0},
        '{16'h0000,16'h0C20,16'h0C60,16'h00C0,16'h0180,16'h0300,16'h0660,16'h0C60},
        '{16'h0000,16'h01C0,16'h1BE0,16'h3E20,16'h2720,16'h3DC0,16'h1BE0,16'h0220},
        '{16'h0000,16'h0800,16'h7800,16'h7000,16'h0000,16'h0000,16'h0000,16'h0000},
        '{16'h0000,16'h0000,16'h0F80,16'h1FC0,16'h3060,16'h2020,16'h0000,16'h0000},
        '{16'h0000,16'h0000,16'h0000,16'h2020,16'h3060,16'h1FC0,16'h0F80,16'h0000},
        '{16'h0200,16'h0A80,16'h0F80,16'h0700,16'h0700,16'h0F80,16'h0A80,16'h0200},
        '{16'h0200,16'h0200,16'h0200,16'h1FC0,16'h1FC0,16'h0200,16'h0200,16'h0200},
        '{16'h0000,16'h0000,16'h0010,16'h00F0,16'h00E0,16'h0000,16'h0000,16'h0000},
        '{16'h0200,16'h0200,16'h0200,16'h0200,16'h0200,16'h0200,16'h0200,16'h0200},
        '{16'h0000,16'h0000,16'h0000,16'h0060,16'h0060,16'h0000,16'h0000,16'h0000},
        '{16'h0000,16'h00C0,16'h0180,16'h0300,16'h0600,16'h0C00,16'h1800,16'h3000},
        '{16'h0000,16'h1FC0,16'h3FE0,16'h2320,16'h2620,16'h2C20,16'h3FE0,16'h1FC0},
        '{16'h0000,16'h0000,16'h0820,16'h1820,16'h3FE0,16'h3FE0,16'h0020,16'h0020},
        '{16'h0000,16'h1060,16'h30E0,16'h21A0,16'h2320,16'h2620,16'h3C60,16'h1860},
        '{16'h0000,16'h1040,16'h3060,16'h2220,16'h2220,16'h2220,16'h3FE0,16'h1DC0},
        '{16'h0000,16'h0300,16'h0700,16'h0D00,16'h1920,16'h3FE0,16'h3FE0,16'h0120},
        '{16'h0000,16'h3E40,16'h3E60,16'h2220,16'h2220,16'h2220,16'h23E0,16'h21C0},
        '{16'h0000,16'h0FC0,16'h1FE0,16'h3220,16'h2220,16'h2220,16'h03E0,16'h01C0},
        '{16'h0000,16'h3000,16'h3000,16'h21E0,16'h23E0,16'h2600,16'h3C00,16'h3800},
        '{16'h0000,16'h1DC0,16'h3FE0,16'h2220,16'h2220,16'h2220,16'h3FE0,16'h1DC0},
        '{16'h0000,16'h1C00,16'h3E20,16'h2220,16'h2220,16'h2260,16'h3FC0,16'h1F80},
        '{16'h0000,16'h0000,16'h0000,16'h18C0,16'h18C0,16'h0000,16'h0000,16'h0000},
        '{16'h0000,16'h0000,16'h0020,16'h18E0,16'h18C0,16'h0000,16'h0000,16'h0000},
        '{16'h0000,16'h0200,16'h0700,16'h0D80,16'h18C0,16'h3060,16'h2020,16'h0000},
        '{16'h0000,16'h0480,16'h0480,16'h0480,16'h0480,16'h0480,16'h0480,16'h0000},
        '{16'h0000,16'h2020,16'h3060,16'h18C0,16'h0D80,16'h0700,16'h0200,16'h0000},
        '{16'h0000,16'h1800,16'h3800,16'h2000,16'h2360,16'h2760,16'h3C00,16'h1800},
        '{16'h0000,16'h1FC0,16'h3FE0,16'h2020,16'h27A0,16'h27A0,16'h3FA0,16'h1F00},
        '{16'h0000,16'h07E0,16'h0FE0,16'h1900,16'h3100,16'h1900,16'h0FE0,16'h07E0},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2220,16'h2220,16'h3FE0,16'h1DC0},
        '{16'h0000,16'h0F80,16'h1FC0,16'h3060,16'h2020,16'h2020,16'h3060,16'h18C0},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2020,16'h3060,16'h1FC0,16'h0F80},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2220,16'h2720,16'h3060,16'h38E0},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2220,16'h2700,16'h3000,16'h3800},
        '{16'h0000,16'h0F80,16'h1FC0,16'h3060,16'h2120,16'h2120,16'h31C0,16'h19E0},
        '{16'h0000,16'h3FE0,16'h3FE0,16'h0200,16'h0200,16'h0200,16'h3FE0,16'h3FE0},
        '{16'h0000,16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2020,16'h0000,16'h0000},
        '{16'h0000,16'h00C0,16'h00E0,16'h0020,16'h2020,16'h3FE0,16'h3FC0,16'h2000},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h0200,16'h0F80,16'h3DE0,16'h3060},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2020,16'h0020,16'h0060,16'h00E0},
        '{16'h3FE0,16'h3FE0,16'h1800,16'h0C00,16'h0C00,16'h1800,16'h3FE0,16'h3FE0},
        '{16'h0000,16'h3FE0,16'h3FE0,16'h1C00,16'h0E00,16'h0700,16'h3FE0,16'h3FE0},
        '{16'h0000,16'h0F80,16'h1FC0,16'h3060,16'h2020,16'h3060,16'h1FC0,16'h0F80},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2220,16'h2200,16'h3E00,16'h1C00},
        '{16'h0000,16'h1F80,16'h3FC0,16'h2040,16'h21C0,16'h20F0,16'h3FF0,16'h1F90},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h2200,16'h2300,16'h3FE0,16'h1CE0},
        '{16'h0000,16'h18C0,16'h3CE0,16'h2620,16'h2220,16'h2320,16'h39E0,16'h18C0},
        '{16'h3800,16'h3000,16'h2020,16'h3FE0,16'h3FE0,16'h2020,16'h3000,16'h3800},
        '{16'h0000,16'h3FC0,16'h3FE0,16'h0020,16'h0020,16'h0020,16'h3FE0,16'h3FC0},
        '{16'h3F00,16'h3F80,16'h00C0,16'h0060,16'h0060,16'h00C0,16'h3F80,16'h3F00},
        '{16'h3F80,16'h3FE0,16'h00E0,16'h0380,16'h0380,16'h00E0,16'h3FE0,16'h3F80},
        '{16'h3060,16'h38E0,16'h0D80,16'h0700,16'h0700,16'h0D80,16'h38E0,16'h3060},
        '{16'h3800,16'h3C00,16'h0620,16'h03E0,16'h03E0,16'h0620,16'h3C00,16'h3800},
        '{16'h3860,16'h30E0,16'h21A0,16'h2320,16'h2620,16'h2C20,16'h3860,16'h30E0},
        '{16'h0000,16'h0000,16'h3FE0,16'h3FE0,16'h2020,16'h2020,16'h0000,16'h0000},
        '{16'h0000,16'h3800,16'h1C00,16'h0E00,16'h0700,16'h0380,16'h01C0,16'h00E0},
        '{16'h0000,16'h0000,16'h2020,16'h2020,16'h3FE0,16'h3FE0,16'h0000,16'h0000},
        '{16'h0000,16'h1000,16'h3000,16'h6000,16'hC000,16'h6000,16'h3000,16'h1000},
        '{16'h0008,16'h0008,16'h0008,16'h0008,16'h0008,16'h0008,16'h0008,16'h0008},
        '{16'h0000,16'h0000,16'h0000,16'hC000,16'hE000,16'h2000,16'h0000,16'h0000},
        '{16'h0000,16'h00C0,16'h05E0,16'h0520,16'h0520,16'h07C0,16'h03E0,16'h0020},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FC0,16'h0420,16'h0620,16'h03E0,16'h01C0},
        '{16'h0000,16'h03C0,16'h07E0,16'h0420,16'h0420,16'h0420,16'h0660,16'h0240},
        '{16'h0000,16'h01C0,16'h03E0,16'h0620,16'h2420,16'h3FC0,16'h3FE0,16'h0020},
        '{16'h0000,16'h03C0,16'h07E0,16'h0520,16'h0520,16'h0520,16'h0760,16'h0340},
        '{16'h0000,16'h0220,16'h1FE0,16'h3FE0,16'h2220,16'h3200,16'h1800,16'h0000},
        '{16'h0000,16'h0390,16'h07D8,16'h0448,16'h0448,16'h03F8,16'h07F0,16'h0400},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h0200,16'h0400,16'h07E0,16'h03E0},
        '{16'h0000,16'h0000,16'h0000,16'h0420,16'h37E0,16'h37E0,16'h0020,16'h0000},
        '{16'h0000,16'h0030,16'h0038,16'h0008,16'h0408,16'h37F8,16'h37F0,16'h0000},
        '{16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h0100,16'h0380,16'h06E0,16'h0460},
        '{16'h0000,16'h0000,16'h0000,16'h2020,16'h3FE0,16'h3FE0,16'h0020,16'h0000},
        '{16'h07E0,16'h07E0,16'h0600,16'h03E0,16'h03E0,16'h0600,16'h07E0,16'h03E0},
        '{16'h0000,16'h0400,16'h07E0,16'h03E0,16'h0400,16'h0400,16'h07E0,16'h03E0},
        '{16'h0000,16'h03C0,16'h07E0,16'h0420,16'h0420,16'h0420,16'h07E0,16'h03C0},
        '{16'h0000,16'h0408,16'h07F8,16'h03F8,16'h0448,16'h0440,16'h07C0,16'h0380},
        '{16'h0000,16'h0380,16'h07C0,16'h0440,16'h0448,16'h03F8,16'h07F8,16'h0408},
        '{16'h0000,16'h0420,16'h07E0,16'h03E0,16'h0620,16'h0400,16'h0700,16'h0300},
        '{16'h0000,16'h0240,16'h0760,16'h0520,16'h05A0,16'h04A0,16'h06E0,16'h0240},
        '{16'h0000,16'h0400,16'h0400,16'h1FC0,16'h3FE0,16'h0420,16'h0460,16'h0040},
        '{16'h0000,16'h07C0,16'h07E0,16'h0020,16'h0020,16'h07C0,16'h07E0,16'h0020},
        '{16'h0700,16'h0780,16'h00C0,16'h0060,16'h0060,16'h00C0,16'h0780,16'h0700},
        '{16'h07C0,16'h07E0,16'h0060,16'h01C0,16'h01C0,16'h0060,16'h07E0,16'h07C0},
        '{16'h0000,16'h0420,16'h0660,16'h03C0,16'h0180,16'h03C0,16'h0660,16'h0420},
        '{16'h0000,16'h0780,16'h07C8,16'h0048,16'h0048,16'h0058,16'h07F0,16'h07E0},
        '{16'h0000,16'h0620,16'h0660,16'h04E0,16'h05A0,16'h0720,16'h0660,16'h0460},
        '{16'h0000,16'h0200,16'h0200,16'h1FC0,16'h3DE0,16'h2020,16'h2020,16'h0000},
        '{16'h0000,16'h0000,16'h0000,16'h3DE0,16'h3DE0,16'h0000,16'h0000,16'h0000},
        '{16'h0000,16'h2020,16'h2020,16'h3DE0,16'h1FC0,16'h0200,16'h0200,16'h0000},
        '{16'h0000,16'h1000,16'h3000,16'h2000,16'h3000,16'h1000,16'h3000,16'h2000},
        '{16'h0000,16'h01C0,16'h03C0,16'h0640,16'h0C40,16'h0640,16'h03C0,16'h01C0}
    };

    // Gathers all column words of one glyph into one packed word, column 0 lowest.
    function automatic glyph_bits_t font_glyph(input logic [GLYPH_IDX_W-1:0] idx);
        glyph_bits_t g;
        for (int c = 0; c < GLYPH_COLUMNS; c++)
        begin
            g[c] = FONT_ROM[idx][c];
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> sv/cgr_front.sv
// Front end: classifies each character code and fetches its glyph from the font.
`default_nettype none

module cgr_front
    import cgr_pkg::*;
(
    input  wire logic [CODE_W-1:0] char_code,
    output q_entry_t               entry
);

    logic                   in_font;
    logic [GLYPH_IDX_W-1:0] glyph_idx;

    // Codes outside the printable range fall back to the space glyph.
    assign in_font   = (char_code >= CODE_W'(FIRST_CODE)) &&
                       (char_code <  CODE_W'(FIRST_CODE + GLYPH_COUNT));
    assign glyph_idx = in_font ? GLYPH_IDX_W'(char_code - CODE_W'(FIRST_CODE))
                               : '0;

    assign entry.is_end = (char_code == '0);
    assign entry.glyph  = font_glyph(glyph_idx);

endmodule

`default_nettype wire

>>> sv/cgr_queue.sv
// Two-entry queue between the front end and the pixel sequencer.
`default_nettype none

module cgr_queue
    import cgr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  q_entry_t  wr_entry,
    input  wire logic pop,
    output q_entry_t  rd_entry,
    output q_status_t status
);

    q_entry_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_entry     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> sv/cgr_back.sv
// Back end: configuration registers and the column sequencer that emits pixel groups.
`default_nettype none

module cgr_back
    import cgr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    input  q_entry_t                  head,
    input  q_status_t                 q_stat,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [COLOR_W-1:0]        pixel_a,
    output logic [COLOR_W-1:0]        pixel_b,
    output logic [COLOR_W-1:0]        pixel_c,
    output logic [COLOR_W-1:0]        pixel_d,
    output logic [COLOR_W-1:0]        pixel_e,
    output logic [COLOR_W-1:0]        pixel_f,
    output logic [COLOR_W-1:0]        pixel_g,
    output logic [COL_W-1:0]          column_index,
    output logic                      lower_half,
    output logic                      last_of_run
);

    color_t           fore_color_reg;
    color_t           back_color_reg;
    logic             invert_mode_reg;
    color_t           blank_color_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             half_reg;
    logic             half_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    color_t           pix_reg  [HALF_ROWS];
    color_t           pix_next [HALF_ROWS];
    logic [COL_W-1:0] out_col_reg;
    logic             out_half_reg;
    logic             out_last_reg;

    logic             advance;
    logic             item_last;
    color_t           on_color;
    color_t           off_color;
    font_word_t       col_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_color_reg  <= FORE_COLOR_RST;
            back_color_reg  <= BACK_COLOR_RST;
            invert_mode_reg <= 1'b0;
            blank_color_reg <= BLANK_COLOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORE_COLOR:  fore_color_reg  <= cfg_data;
                REG_BACK_COLOR:  back_color_reg  <= cfg_data;
                REG_INVERT_MODE: invert_mode_reg <= cfg_data[0];
                REG_BLANK_COLOR: blank_color_reg <= cfg_data;
            endcase
        end
    end

    // A new group is produced whenever the queue holds an entry and the output register is free or being taken.
    assign advance   = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign item_last = half_reg &&
                       (head.is_end || (col_reg == COL_W'(GLYPH_COLUMNS - 1)));
    assign pop       = advance && item_last;

    assign on_color  = invert_mode_reg ? back_color_reg : fore_color_reg;
    assign off_color = invert_mode_reg ? fore_color_reg : back_color_reg;
    assign col_word  = head.glyph[col_reg];

    always_comb
    begin
        logic [ROW_BIT_W-1:0] bit_sel;
        bit_sel        = '0;
        col_next       = col_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        for (int r = 0; r < HALF_ROWS; r++)
        begin
            bit_sel     = ROW_BIT_W'(r + ROW_BIT_OFFSET) +
                          (half_reg ? ROW_BIT_W'(HALF_ROWS) : '0);
            pix_next[r] = head.is_end ? blank_color_reg
                                      : (col_word[bit_sel] ? on_color : off_color);
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            half_next      = !half_reg;
            if (item_last)
            begin
                col_next = '0;
            end
            else if (half_reg)
            begin
                col_next = col_reg + 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg      <= pix_next;
            out_col_reg  <= col_reg;
            out_half_reg <= half_reg;
            out_last_reg <= item_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_a      = pix_reg[0];
    assign pixel_b      = pix_reg[1];
    assign pixel_c      = pix_reg[2];
    assign pixel_d      = pix_reg[3];
    assign pixel_e      = pix_reg[4];
    assign pixel_f      = pix_reg[5];
    assign pixel_g      = pix_reg[6];
    assign column_index = out_col_reg;
    assign lower_half   = out_half_reg;
    assign last_of_run  = out_last_reg;

    a_pop_on_lower: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> half_reg)
        else $error("queue entry released before its lower half was sent");

    a_end_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && head.is_end) |-> (col_reg == '0))
        else $error("end of string entry started mid-glyph");

    a_last_meta: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
            (out_half_reg && (out_col_reg == COL_W'(GLYPH_COLUMNS - 1) ||
                              out_col_reg == '0)))
        else $error("last group flagged at a wrong column");

endmodule

`default_nettype wire

>>> sv/character_glyph_rasterizer_core.sv
// Top level of the character glyph rasterizer: front end, queue and pixel sequencer.
//
// Usage: the input channel (in_valid, in_stall, char_code) takes one character
// code per transaction. Codes 32 to 127 are drawn from the built-in 8x14 font,
// other nonzero codes are drawn as a space, and code 0 ends the string with one
// blank column. The output channel (out_valid, out_stall and the pixel fields)
// carries one group of seven RGB565 pixels per transaction: each glyph column is
// sent as its upper half then its lower half, so a character gives 16
// transactions and the end code gives 2; last_of_run marks the final one.
// An accepted character is written into the queue, and the sequencer then
// registers its groups in the output register. Throughput: one group per cycle
// from the sequencer while the queue holds an entry and the receiver does not
// stall; the single output register sets this rate. A two-entry queue between
// the front end and the sequencer lets characters be accepted while earlier
// ones drain. Reset clears the queue and out_valid and loads the default colors
// (white foreground, black background and blank, no inversion). When the
// receiver stalls, the output group holds and the sequencer waits; in_stall
// rises once the queue is full. Configuration writes belong in idle periods.
`default_nettype none

module character_glyph_rasterizer_core
    import cgr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CODE_W-1:0]    char_code,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [COLOR_W-1:0]        pixel_a,
    output logic [COLOR_W-1:0]        pixel_b,
    output logic [COLOR_W-1:0]        pixel_c,
    output logic [COLOR_W-1:0]        pixel_d,
    output logic [COLOR_W-1:0]        pixel_e,
    output logic [COLOR_W-1:0]        pixel_f,
    output logic [COLOR_W-1:0]        pixel_g,
    output logic [COL_W-1:0]          column_index,
    output logic                      lower_half,
    output logic                      last_of_run
);

    q_entry_t  front_entry;
    q_entry_t  head_entry;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;

    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !q_stat.full;

    cgr_front u_front (
        .char_code (char_code),
        .entry     (front_entry)
    );

    cgr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (front_entry),
        .pop      (q_pop),
        .rd_entry (head_entry),
        .status   (q_stat)
    );

    cgr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head         (head_entry),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_a      (pixel_a),
        .pixel_b      (pixel_b),
        .pixel_c      (pixel_c),
        .pixel_d      (pixel_d),
        .pixel_e      (pixel_e),
        .pixel_f      (pixel_f),
        .pixel_g      (pixel_g),
        .column_index (column_index),
        .lower_half   (lower_half),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
